@@ rtl/srtp_pkg.sv @@
package srtp_pkg;

  typedef enum logic [1:0] {
    REQ_IRQ   = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_ENTRY = 2'd2,
    REQ_EXIT  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_RATIO_START = 2'd0,
    CFG_DEPTH_START = 2'd1
  } cfg_index_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [31:0] RatioReset = 32'd16;
  localparam logic [15:0] DepthTrigReset = 16'd4;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [15:0] Max16 = 16'hFFFF;

  typedef struct packed {
    req_type_e req_type;
    logic      paused;
  } srtp_in_t;

  typedef struct packed {
    logic        relocate_sync;
    logic        relocate_irq;
    logic [31:0] loop_ratio_now;
    logic [15:0] depth_trigger_now;
    logic [15:0] depth_now;
    logic [31:0] sync_total;
    logic [31:0] irq_total;
    logic        irq_seen_paused;
  } srtp_out_t;

endpackage

@@ rtl/stack_relocation_trigger_policy_core.sv @@
// Stack relocation trigger policy core.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
// transaction: interrupt, outer loop tick, call entry or call exit. Output
// channel (out_valid_o / out_stall_i / out_data_o) returns exactly one result
// per event, in order: relocation pulses plus ratio, depth, trigger and
// counter status after that event.
// The result of an accepted event is registered in the result register, or
// in the skid buffer while the output stalls. Throughput: one event per cycle
// while in_stall_o is low. Policy state updates by compares and increments;
// the one-entry skid buffer lets an event be taken while a result still waits.
// Stall: while out_stall_i holds, the result stays put; the skid buffer
// takes one more event, then in_stall_o rises until the result is taken.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 reloads the loop ratio, index 1 the depth trigger, other indexes
// are ignored. Write only while idle. cfg_ready_o is always high.
// Reset (rst_ni low, async): ratio 16, depth trigger 4, counters, depth and
// flags cleared, both channel buffers empty.
module stack_relocation_trigger_policy_core
  import srtp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srtp_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srtp_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        hinted_q, hinted_d;
  logic        last_irq_q, last_irq_d;
  logic [31:0] ratio_q, ratio_d;
  logic [31:0] ticks_q, ticks_d;
  logic [15:0] depth_q, depth_d;
  logic [15:0] trig_q, trig_d;
  logic [31:0] sync_cnt_q, sync_cnt_d;
  logic [31:0] irq_cnt_q, irq_cnt_d;
  logic        paused_flag_q, paused_flag_d;

  logic        out_valid_q, out_valid_d;
  srtp_out_t   out_data_q, out_data_d;
  logic        skid_valid_q, skid_valid_d;
  srtp_out_t   skid_data_q, skid_data_d;

  logic        accept;
  logic        cfg_wr;
  logic        hint_req;
  logic        sync_pulse;
  logic        irq_pulse;
  logic [31:0] ratio_dec;
  logic [15:0] depth_inc;
  srtp_out_t   res;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    hinted_d      = hinted_q;
    last_irq_d    = last_irq_q;
    ratio_d       = ratio_q;
    ticks_d       = ticks_q;
    depth_d       = depth_q;
    trig_d        = trig_q;
    sync_cnt_d    = sync_cnt_q;
    irq_cnt_d     = irq_cnt_q;
    paused_flag_d = paused_flag_q;
    hint_req      = 1'b0;
    irq_pulse     = 1'b0;
    ratio_dec     = (last_irq_q && ratio_q > 32'd1) ? ratio_q - 32'd1 : ratio_q;
    depth_inc     = (depth_q != Max16) ? depth_q + 16'd1 : depth_q;

    unique case (in_data_i.req_type)
      REQ_IRQ: begin
        if (in_data_i.paused) begin
          paused_flag_d = 1'b1;
        end else if (!hinted_q) begin
          irq_pulse  = 1'b1;
          last_irq_d = 1'b1;
          irq_cnt_d  = (irq_cnt_q != Max32) ? irq_cnt_q + 32'd1 : irq_cnt_q;
          if (depth_q > trig_q && trig_q != Max16) begin
            trig_d = trig_q + 16'd1;
          end
        end else begin
          hinted_d = 1'b0;
        end
      end
      REQ_TICK: begin
        if (ticks_q >= ratio_q) begin
          if (hinted_q) begin
            ratio_d = ratio_dec[31] ? Max32 : {ratio_dec[30:0], 1'b0};
          end else begin
            ratio_d = ratio_dec;
          end
          hint_req = 1'b1;
          ticks_d  = '0;
        end else begin
          ticks_d = (ticks_q != Max32) ? ticks_q + 32'd1 : ticks_q;
        end
      end
      REQ_ENTRY: begin
        depth_d = depth_inc;
        if (depth_inc == trig_q) begin
          if (hinted_q && trig_q > 16'd1) begin
            trig_d = trig_q - 16'd1;
          end
          hint_req = 1'b1;
        end
      end
      REQ_EXIT: begin
        depth_d = (depth_q != '0) ? depth_q - 16'd1 : depth_q;
      end
      default: ;
    endcase

    sync_pulse = hint_req && !hinted_q;
    if (sync_pulse) begin
      hinted_d   = 1'b1;
      last_irq_d = 1'b0;
      sync_cnt_d = (sync_cnt_q != Max32) ? sync_cnt_q + 32'd1 : sync_cnt_q;
    end

    res.relocate_sync     = sync_pulse;
    res.relocate_irq      = irq_pulse;
    res.loop_ratio_now    = ratio_d;
    res.depth_trigger_now = trig_d;
    res.depth_now         = depth_d;
    res.sync_total        = sync_cnt_d;
    res.irq_total         = irq_cnt_d;
    res.irq_seen_paused   = paused_flag_d;
  end

  // result register with one-entry skid buffer
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_data_d  = res;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hinted_q      <= 1'b0;
      last_irq_q    <= 1'b0;
      ratio_q       <= RatioReset;
      ticks_q       <= '0;
      depth_q       <= '0;
      trig_q        <= DepthTrigReset;
      sync_cnt_q    <= '0;
      irq_cnt_q     <= '0;
      paused_flag_q <= 1'b0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (accept) begin
        hinted_q      <= hinted_d;
        last_irq_q    <= last_irq_d;
        ratio_q       <= ratio_d;
        ticks_q       <= ticks_d;
        depth_q       <= depth_d;
        trig_q        <= trig_d;
        sync_cnt_q    <= sync_cnt_d;
        irq_cnt_q     <= irq_cnt_d;
        paused_flag_q <= paused_flag_d;
      end else if (cfg_wr) begin
        if (cfg_index_i == CFG_RATIO_START) begin
          ratio_q <= {16'd0, cfg_data_i};
        end else if (cfg_index_i == CFG_DEPTH_START) begin
          trig_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/srtp_checker.sv @@
module srtp_checker
  import srtp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input srtp_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.relocate_sync && out_data_o.relocate_irq))
    else $error("sync and irq relocation in one result");

  a_irq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.relocate_irq |-> out_data_o.irq_total != 32'd0)
    else $error("irq relocation without count");

  a_sync_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.relocate_sync |-> out_data_o.sync_total != 32'd0)
    else $error("sync relocation without count");

  a_no_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind stack_relocation_trigger_policy_core srtp_checker u_srtp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
